/* sv/pvd_pkg.sv */
package pvd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned VAL_W  = 64;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned POS_W  = 7;

  // Largest length whose lead byte carries value bits.
  localparam logic [LEN_W-1:0] LEAD_PAYLOAD_MAX = 4'd7;
  // Largest length that is sign-extended.
  localparam logic [LEN_W-1:0] SEXT_LEN_MAX     = 4'd8;
  localparam logic [LEN_W-1:0] LEN_MAX          = 4'd9;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              cmd;
  } pvd_byte_t;

  // Registered input word handed to the decode stage.
  typedef struct packed {
    logic      valid;
    pvd_byte_t word;
  } pvd_stage_t;

endpackage

/* sv/pvd_if.sv */
interface pvd_byte_if;
  logic                           valid;
  logic                           ready;
  logic [pvd_pkg::BYTE_W-1:0]     data_byte;
  logic                           cmd;

  modport source (output valid, output data_byte, output cmd, input ready);
  modport sink   (input valid, input data_byte, input cmd, output ready);
endinterface

interface pvd_res_if;
  logic                           valid;
  logic                           ready;
  logic [pvd_pkg::VAL_W-1:0]      value;
  logic [pvd_pkg::LEN_W-1:0]      length;

  modport source (output valid, output value, output length, input ready);
  modport sink   (input valid, input value, input length, output ready);
endinterface

/* sv/pvd_in_reg.sv */
module pvd_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  pvd_byte_if.sink             in_word,
  input  logic                 take,
  output pvd_pkg::pvd_stage_t  stg
);

  logic               valid_r;
  pvd_pkg::pvd_byte_t word_r;

  // Accept whenever the register is empty or drains this cycle.
  assign in_word.ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_word.valid && in_word.ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_word.valid && in_word.ready) begin
      word_r.data_byte <= in_word.data_byte;
      word_r.cmd       <= in_word.cmd;
    end
  end

  assign stg.valid = valid_r;
  assign stg.word  = word_r;

endmodule

/* sv/pvd_core.sv */
module pvd_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pvd_pkg::pvd_stage_t  stg,
  output logic                 take,
  pvd_res_if.source            out_word
);

  localparam int unsigned VW = pvd_pkg::VAL_W;
  localparam int unsigned LW = pvd_pkg::LEN_W;
  localparam int unsigned PW = pvd_pkg::POS_W;

  logic [VW-1:0] acc_r, acc_nxt;
  logic [LW-1:0] left_r, left_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [LW-1:0] total_r, total_nxt;
  logic          sgn_r, sgn_nxt;

  logic          out_valid_r;
  logic [VW-1:0] out_value_r, out_value_nxt;
  logic [LW-1:0] out_length_r;

  logic [LW-1:0] lead_len;
  logic          done;

  // Leading ones plus one.
  function automatic logic [LW-1:0] lead_length(input logic [7:0] b);
    logic [LW-1:0] n;
    priority if (!b[7]) n = 4'd1;
    else if (!b[6])     n = 4'd2;
    else if (!b[5])     n = 4'd3;
    else if (!b[4])     n = 4'd4;
    else if (!b[3])     n = 4'd5;
    else if (!b[2])     n = 4'd6;
    else if (!b[1])     n = 4'd7;
    else if (!b[0])     n = 4'd8;
    else                n = 4'd9;
    return n;
  endfunction

  // Sign-extend from bit 7*len-1 for lengths up to eight when sgn is set.
  function automatic logic [VW-1:0] finish(input logic [VW-1:0] v,
                                           input logic [LW-1:0] len,
                                           input logic          sgn);
    logic [PW-1:0] width;
    logic [VW-1:0] low_mask;
    logic          sbit;
    width    = ({3'b000, len} << 3) - {3'b000, len};
    low_mask = (64'd1 << width) - 64'd1;
    // Top bit of the low mask is the sign bit.
    sbit     = |(v & low_mask & ~(low_mask >> 1));
    if (sgn && len <= pvd_pkg::SEXT_LEN_MAX && sbit) begin
      return v | ~low_mask;
    end
    return v;
  endfunction

  assign take     = stg.valid && (!out_valid_r || out_word.ready);
  assign lead_len = lead_length(stg.word.data_byte);

  always_comb begin
    acc_nxt   = acc_r;
    left_nxt  = left_r;
    pos_nxt   = pos_r;
    total_nxt = total_r;
    sgn_nxt   = sgn_r;
    done      = 1'b0;
    if (left_r == '0) begin
      total_nxt = lead_len;
      sgn_nxt   = stg.word.cmd;
      if (lead_len <= pvd_pkg::LEAD_PAYLOAD_MAX) begin
        acc_nxt = VW'(stg.word.data_byte & (8'hFF >> lead_len));
        pos_nxt = {3'b000, 4'd8 - lead_len};
      end else begin
        acc_nxt = '0;
        pos_nxt = '0;
      end
      if (lead_len == 4'd1) begin
        done = 1'b1;
      end else begin
        left_nxt = lead_len - 4'd1;
      end
    end else begin
      if (!pos_r[PW-1]) begin
        acc_nxt = acc_r | (VW'(stg.word.data_byte) << pos_r[PW-2:0]);
      end
      pos_nxt  = pos_r + 7'd8;
      left_nxt = left_r - 4'd1;
      done     = (left_r == 4'd1);
    end
    out_value_nxt = finish(acc_nxt, total_nxt, sgn_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      left_r      <= '0;
      pos_r       <= '0;
      total_r     <= '0;
      sgn_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        acc_r   <= acc_nxt;
        left_r  <= left_nxt;
        pos_r   <= pos_nxt;
        total_r <= total_nxt;
        sgn_r   <= sgn_nxt;
      end
      if (take && done) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && done) begin
      out_value_r  <= out_value_nxt;
      out_length_r <= total_nxt;
    end
  end

  assign out_word.valid  = out_valid_r;
  assign out_word.value  = out_value_r;
  assign out_word.length = out_length_r;

  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= pvd_pkg::SEXT_LEN_MAX)
    else $error("tail count out of range");

  a_pos_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    left_r != '0 |-> !pos_r[PW-1])
    else $error("tail position beyond word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_word.ready |-> !take)
    else $error("decode advanced over a stalled result");

  a_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
    take && left_r == '0 && !stg.word.data_byte[7]
      |=> out_valid_r && out_length_r == 4'd1)
    else $error("single-byte integer not emitted");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_length_r != '0 && out_length_r <= pvd_pkg::LEN_MAX)
    else $error("result length out of range");

endmodule

/* sv/prefix_varint_decoder.sv */
// A byte is first held in the input register; the byte that completes an integer is
// then decoded into the result register, from which the result is offered.
// Throughput: one byte per cycle; the decode stage advances whenever the result
// register is empty or being taken.
// Reset: synchronous, active low; the decoder restarts expecting a lead byte.
module prefix_varint_decoder (
  input  logic       clk,
  input  logic       rst_n,
  pvd_byte_if.sink   in_word,
  pvd_res_if.source  out_word
);

  pvd_pkg::pvd_stage_t stg;
  logic                take;

  pvd_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word),
    .take    (take),
    .stg     (stg)
  );

  pvd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .stg      (stg),
    .take     (take),
    .out_word (out_word)
  );

endmodule
